// ===== rtl/sec_pkg.sv =====
// Shared types and constants for the segment edge coverage block.
package sec_pkg;

  localparam int CoordW   = 16;
  localparam int CoordE   = (CoordW > 30) ? 30 : CoordW;
  localparam int HalfW    = 12;
  localparam int FeatherW = 12;
  localparam int OutW     = 16;
  localparam int QuoW     = 16;

  localparam logic [FeatherW-1:0] FeatherReset = 12'd256;

  typedef enum logic [1:0] {
    SelZero = 2'b00,
    SelOne  = 2'b01,
    SelDiv  = 2'b10
  } sel_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic [HalfW-1:0]         half_width;
  } item_t;

  typedef struct packed {
    logic [OutW-1:0] coverage;
    logic [OutW-1:0] distance;
  } result_t;

endpackage

// ===== rtl/sec_div.sv =====
// Pipelined restoring divider: floor((num << QuoW) / den), num < den, one bit per stage.
module sec_div #(
  parameter int DivW  = 12,
  parameter int QuoW  = 16,
  parameter int SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [DivW-1:0]  num_i,
  input  logic [DivW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QuoW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  logic [QuoW-1:0]  v_q;
  logic [DivW-1:0]  rem_q  [QuoW];
  logic [DivW-1:0]  den_q  [QuoW];
  logic [QuoW-1:0]  quo_q  [QuoW];
  logic [SideW-1:0] side_q [QuoW];

  logic [DivW-1:0]  cur_rem  [QuoW];
  logic [DivW-1:0]  cur_den  [QuoW];
  logic [QuoW-1:0]  cur_quo  [QuoW];
  logic [SideW-1:0] cur_side [QuoW];
  logic [QuoW-1:0]  cur_v;

  logic [DivW-1:0]  rem_d [QuoW];
  logic [QuoW-1:0]  quo_d [QuoW];

  always_comb begin
    cur_rem[0]  = num_i;
    cur_den[0]  = den_i;
    cur_quo[0]  = '0;
    cur_side[0] = side_i;
    cur_v[0]    = valid_i;
    for (int i = 1; i < QuoW; i++) begin
      cur_rem[i]  = rem_q[i-1];
      cur_den[i]  = den_q[i-1];
      cur_quo[i]  = quo_q[i-1];
      cur_side[i] = side_q[i-1];
      cur_v[i]    = v_q[i-1];
    end
  end

  always_comb begin
    logic [DivW:0] r2;
    for (int i = 0; i < QuoW; i++) begin
      r2 = {cur_rem[i], 1'b0};
      if (r2 >= {1'b0, cur_den[i]}) begin
        rem_d[i] = DivW'(r2 - {1'b0, cur_den[i]});
        quo_d[i] = {cur_quo[i][QuoW-2:0], 1'b1};
      end else begin
        rem_d[i] = r2[DivW-1:0];
        quo_d[i] = {cur_quo[i][QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= cur_v;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QuoW; i++) begin
      rem_q[i]  <= rem_d[i];
      den_q[i]  <= cur_den[i];
      quo_q[i]  <= quo_d[i];
      side_q[i] <= cur_side[i];
    end
  end

  assign valid_o = v_q[QuoW-1];
  assign quo_o   = quo_q[QuoW-1];
  assign side_o  = side_q[QuoW-1];

endmodule

// ===== rtl/sec_sqrt.sv =====
// Pipelined integer square root (floor), one root bit per stage.
module sec_sqrt #(
  parameter int RootW = 18,
  parameter int SideW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [2*RootW-1:0] rad_i,
  input  logic [SideW-1:0]   side_i,
  output logic               valid_o,
  output logic [RootW-1:0]   root_o,
  output logic [SideW-1:0]   side_o
);

  localparam int RemW = RootW + 2;
  localparam int RadW = 2 * RootW;

  logic [RootW-1:0] v_q;
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [RadW-1:0]  rad_q  [RootW];
  logic [SideW-1:0] side_q [RootW];

  logic [RemW-1:0]  cur_rem  [RootW];
  logic [RootW-1:0] cur_root [RootW];
  logic [RadW-1:0]  cur_rad  [RootW];
  logic [SideW-1:0] cur_side [RootW];
  logic [RootW-1:0] cur_v;

  logic [RemW-1:0]  rem_d  [RootW];
  logic [RootW-1:0] root_d [RootW];

  always_comb begin
    cur_rem[0]  = '0;
    cur_root[0] = '0;
    cur_rad[0]  = rad_i;
    cur_side[0] = side_i;
    cur_v[0]    = valid_i;
    for (int i = 1; i < RootW; i++) begin
      cur_rem[i]  = rem_q[i-1];
      cur_root[i] = root_q[i-1];
      cur_rad[i]  = rad_q[i-1];
      cur_side[i] = side_q[i-1];
      cur_v[i]    = v_q[i-1];
    end
  end

  // Bring down the next two radicand bits, try (root << 2) | 1.
  always_comb begin
    logic [RemW+1:0] rn;
    logic [RemW+1:0] trial;
    for (int i = 0; i < RootW; i++) begin
      rn    = {cur_rem[i], cur_rad[i][RadW-1 -: 2]};
      trial = {2'b00, cur_root[i], 2'b01};
      if (rn >= trial) begin
        rem_d[i]  = RemW'(rn - trial);
        root_d[i] = {cur_root[i][RootW-2:0], 1'b1};
      end else begin
        rem_d[i]  = rn[RemW-1:0];
        root_d[i] = {cur_root[i][RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= cur_v;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RootW; i++) begin
      rem_q[i]  <= rem_d[i];
      root_q[i] <= root_d[i];
      rad_q[i]  <= {cur_rad[i][RadW-3:0], 2'b00};
      side_q[i] <= cur_side[i];
    end
  end

  assign valid_o = v_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

// ===== rtl/segment_edge_coverage.sv =====
// Top level: point to segment distance and smoothstep edge coverage pipeline.
//
//  port group          direction  handshake
//  item_i              in         start && !busy at the clock edge
//  cfg_we_i/wdata_i    in         cfg_we_i at the clock edge, feather width
//  result_o            out        done_o, one cycle, no back pressure
//
// One item per cycle; each item passes through the two 16-stage dividers and the
// one-bit-per-stage square root. busy is always low: nothing downstream stalls.
// Reset clears all valid bits and loads a feather width of 256 (FeatherReset).
module segment_edge_coverage import sec_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  item_t               item_i,
  input  logic                cfg_we_i,
  input  logic [FeatherW-1:0] cfg_wdata_i,
  output logic                done_o,
  output result_t             result_o
);

  localparam int CE   = CoordE;
  localparam int DW   = CE + 1;
  localparam int PW   = 2 * DW;
  localparam int LW   = PW - 1;
  localparam int OW   = CE + 2;
  localparam int MW   = CE + 17;
  localparam int RW   = CE + 2;
  localparam int TSW  = 2 + 4 * DW + HalfW;
  localparam int RSW  = 2 + OutW;
  localparam int Lat  = 43 + RW;

  logic [FeatherW-1:0] feather_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feather_q <= FeatherReset;
    end else if (cfg_we_i) begin
      feather_q <= cfg_wdata_i;
    end
  end

  assign busy = 1'b0;

  // Stage A: differences
  logic                 a_v_q;
  logic signed [DW-1:0] a_dx_q, a_dy_q, a_rx_q, a_ry_q;
  logic [HalfW-1:0]     a_half_q;
  logic signed [DW-1:0] px_w, py_w, sx_w, sy_w, ex_w, ey_w;

  assign px_w = {item_i.point_x[CE-1], item_i.point_x[CE-1:0]};
  assign py_w = {item_i.point_y[CE-1], item_i.point_y[CE-1:0]};
  assign sx_w = {item_i.start_x[CE-1], item_i.start_x[CE-1:0]};
  assign sy_w = {item_i.start_y[CE-1], item_i.start_y[CE-1:0]};
  assign ex_w = {item_i.end_x[CE-1], item_i.end_x[CE-1:0]};
  assign ey_w = {item_i.end_y[CE-1], item_i.end_y[CE-1:0]};

  // Stage B: products
  logic                 b_v_q;
  logic signed [PW-1:0] b_xx_q, b_yy_q, b_xd_q, b_yd_q;
  logic signed [DW-1:0] b_dx_q, b_dy_q, b_rx_q, b_ry_q;
  logic [HalfW-1:0]     b_half_q;

  // Stage C: length, dot, projection select
  logic                 c_v_q;
  logic [LW-1:0]        c_num_q, c_den_q;
  logic [TSW-1:0]       c_side_q;
  logic signed [PW-1:0] len2_w, dot_w;
  sel_e                 tsel_w;

  assign len2_w = b_xx_q + b_yy_q;
  assign dot_w  = b_xd_q + b_yd_q;

  // a negative or zero dot product clamps the projection to the start point
  always_comb begin
    if (len2_w == '0 || dot_w[PW-1] || dot_w == '0) begin
      tsel_w = SelZero;
    end else if (dot_w >= len2_w) begin
      tsel_w = SelOne;
    end else begin
      tsel_w = SelDiv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      a_v_q <= start && !busy;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_dx_q   <= ex_w - sx_w;
    a_dy_q   <= ey_w - sy_w;
    a_rx_q   <= px_w - sx_w;
    a_ry_q   <= py_w - sy_w;
    a_half_q <= item_i.half_width;
    b_xx_q   <= a_dx_q * a_dx_q;
    b_yy_q   <= a_dy_q * a_dy_q;
    b_xd_q   <= a_rx_q * a_dx_q;
    b_yd_q   <= a_ry_q * a_dy_q;
    b_dx_q   <= a_dx_q;
    b_dy_q   <= a_dy_q;
    b_rx_q   <= a_rx_q;
    b_ry_q   <= a_ry_q;
    b_half_q <= a_half_q;
    c_num_q  <= (tsel_w == SelDiv) ? dot_w[LW-1:0] : '0;
    c_den_q  <= len2_w[LW-1:0];
    c_side_q <= {tsel_w, b_dx_q, b_dy_q, b_rx_q, b_ry_q, b_half_q};
  end

  logic                 t_v;
  logic [QuoW-1:0]      t_quo;
  logic [TSW-1:0]       t_side;

  sec_div #(
    .DivW  (LW),
    .QuoW  (QuoW),
    .SideW (TSW)
  ) u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_v_q),
    .num_i   (c_num_q),
    .den_i   (c_den_q),
    .side_i  (c_side_q),
    .valid_o (t_v),
    .quo_o   (t_quo),
    .side_o  (t_side)
  );

  sel_e                 ts_w;
  logic signed [DW-1:0] t_dx, t_dy, t_rx, t_ry;
  logic [HalfW-1:0]     t_half;
  logic [QuoW:0]        t_w;
  logic [CE-1:0]        mx_w, my_w;

  assign {ts_w, t_dx, t_dy, t_rx, t_ry, t_half} = t_side;

  always_comb begin
    unique case (ts_w)
      SelOne:  t_w = {1'b1, {QuoW{1'b0}}};
      SelDiv:  t_w = {1'b0, t_quo};
      default: t_w = '0;
    endcase
  end

  assign mx_w = t_dx[DW-1] ? CE'(-t_dx) : t_dx[CE-1:0];
  assign my_w = t_dy[DW-1] ? CE'(-t_dy) : t_dy[CE-1:0];

  // Stage D: |delta| * t
  logic                 d_v_q;
  logic [MW-1:0]        d_pxm_q, d_pym_q;
  logic                 d_nx_q, d_ny_q;
  logic signed [DW-1:0] d_rx_q, d_ry_q;
  logic [HalfW-1:0]     d_half_q;

  // Stage E: offset magnitudes
  logic                 e_v_q;
  logic [OW-2:0]        e_ax_q, e_ay_q;
  logic [HalfW-1:0]     e_half_q;
  logic [MW:0]          rndx_w, rndy_w;
  logic signed [OW-1:0] scx_w, scy_w, ox_w, oy_w;

  assign rndx_w = {1'b0, d_pxm_q} + (MW+1)'(32768);
  assign rndy_w = {1'b0, d_pym_q} + (MW+1)'(32768);
  assign scx_w  = $signed({1'b0, rndx_w[MW-1:16]});
  assign scy_w  = $signed({1'b0, rndy_w[MW-1:16]});
  assign ox_w   = {d_rx_q[DW-1], d_rx_q} - (d_nx_q ? -scx_w : scx_w);
  assign oy_w   = {d_ry_q[DW-1], d_ry_q} - (d_ny_q ? -scy_w : scy_w);

  // Stage F: squares, stage G: sum
  logic                  f_v_q;
  logic [2*OW-3:0]       f_sx_q, f_sy_q;
  logic [HalfW-1:0]      f_half_q;
  logic                  g_v_q;
  logic [2*RW-1:0]       g_d2_q;
  logic [HalfW-1:0]      g_half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
    end else begin
      d_v_q <= t_v;
      e_v_q <= d_v_q;
      f_v_q <= e_v_q;
      g_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_pxm_q  <= mx_w * t_w;
    d_pym_q  <= my_w * t_w;
    d_nx_q   <= t_dx[DW-1];
    d_ny_q   <= t_dy[DW-1];
    d_rx_q   <= t_rx;
    d_ry_q   <= t_ry;
    d_half_q <= t_half;
    e_ax_q   <= ox_w[OW-1] ? (OW-1)'(-ox_w) : ox_w[OW-2:0];
    e_ay_q   <= oy_w[OW-1] ? (OW-1)'(-oy_w) : oy_w[OW-2:0];
    e_half_q <= d_half_q;
    f_sx_q   <= e_ax_q * e_ax_q;
    f_sy_q   <= e_ay_q * e_ay_q;
    f_half_q <= e_half_q;
    g_d2_q   <= (2*RW)'(f_sx_q) + (2*RW)'(f_sy_q);
    g_half_q <= f_half_q;
  end

  logic             s_v;
  logic [RW-1:0]    s_root;
  logic [HalfW-1:0] s_half;

  sec_sqrt #(
    .RootW (RW),
    .SideW (HalfW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_v_q),
    .rad_i   (g_d2_q),
    .side_i  (g_half_q),
    .valid_o (s_v),
    .root_o  (s_root),
    .side_o  (s_half)
  );

  // Stage H: edge ramp select
  logic [31:0]         dist_w, exc_w;
  logic [FeatherW-1:0] fe_w;
  logic [OutW-1:0]     dsat_w;
  sel_e                rsel_w;

  assign dist_w = 32'(s_root);
  assign exc_w  = dist_w - 32'(s_half);
  assign fe_w   = (feather_q == '0) ? FeatherW'(1) : feather_q;
  assign dsat_w = (dist_w > 32'd65535) ? {OutW{1'b1}} : dist_w[OutW-1:0];

  always_comb begin
    if (dist_w <= 32'(s_half)) begin
      rsel_w = SelZero;
    end else if (exc_w >= 32'(fe_w)) begin
      rsel_w = SelOne;
    end else begin
      rsel_w = SelDiv;
    end
  end

  logic                h_v_q;
  logic [FeatherW-1:0] h_num_q, h_den_q;
  logic [RSW-1:0]      h_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q <= 1'b0;
    end else begin
      h_v_q <= s_v;
    end
  end

  always_ff @(posedge clk_i) begin
    h_num_q  <= (rsel_w == SelDiv) ? exc_w[FeatherW-1:0] : '0;
    h_den_q  <= fe_w;
    h_side_q <= {rsel_w, dsat_w};
  end

  logic            r_v;
  logic [QuoW-1:0] r_quo;
  logic [RSW-1:0]  r_side;

  sec_div #(
    .DivW  (FeatherW),
    .QuoW  (QuoW),
    .SideW (RSW)
  ) u_rdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (h_v_q),
    .num_i   (h_num_q),
    .den_i   (h_den_q),
    .side_i  (h_side_q),
    .valid_o (r_v),
    .quo_o   (r_quo),
    .side_o  (r_side)
  );

  sel_e            rs_w;
  logic [OutW-1:0] rd_w;
  logic [QuoW-1:0] r16_w;

  assign {rs_w, rd_w} = r_side;
  assign r16_w = (rs_w == SelDiv) ? r_quo : '0;

  // Stages I, J, K: smoothstep and coverage
  logic            i_v_q, j_v_q, k_v_q;
  logic [31:0]     i_rr_q;
  logic [17:0]     i_k_q;
  logic            i_full_q, j_full_q;
  logic [OutW-1:0] i_dist_q, j_dist_q;
  logic [49:0]     j_p_q;
  logic [50:0]     sm_sum_w;
  logic [18:0]     sm_w;
  logic [OutW-1:0] cov_w;
  result_t         k_res_q;

  assign sm_sum_w = {1'b0, j_p_q} + 51'(64'h8000_0000);
  assign sm_w     = sm_sum_w[50:32];

  always_comb begin
    if (j_full_q || sm_w >= 19'd65536) begin
      cov_w = '0;
    end else if (sm_w == '0) begin
      cov_w = {OutW{1'b1}};
    end else begin
      cov_w = OutW'(19'd65536 - sm_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_v_q <= 1'b0;
      j_v_q <= 1'b0;
      k_v_q <= 1'b0;
    end else begin
      i_v_q <= r_v;
      j_v_q <= i_v_q;
      k_v_q <= j_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i_rr_q           <= r16_w * r16_w;
    i_k_q            <= 18'd196608 - {1'b0, r16_w, 1'b0};
    i_full_q         <= (rs_w == SelOne);
    i_dist_q         <= rd_w;
    j_p_q            <= i_rr_q * i_k_q;
    j_full_q         <= i_full_q;
    j_dist_q         <= i_dist_q;
    k_res_q.coverage <= cov_w;
    k_res_q.distance <= j_dist_q;
  end

  assign done_o   = k_v_q;
  assign result_o = k_res_q;

`ifndef SYNTHESIS
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat done_o)
    else $error("accepted item produced no result");
  a_done_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Lat))
    else $error("result without matching item");
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (j_v_q && j_full_q) |=> (result_o.coverage == '0))
    else $error("full ramp must give zero coverage");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the segment edge coverage block.
`timescale 1ns / 100ps

module tb;
  import sec_pkg::*;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  item_t               item_i;
  logic                cfg_we_i;
  logic [FeatherW-1:0] cfg_wdata_i;
  logic                done_o;
  result_t             result_o;

  logic    row_typed;
  result_t row_want;

  logic [FeatherW-1:0] feather_shadow;
  result_t             coverage_q[$];
  int unsigned         err_cnt;
  int unsigned         cyc_cnt;

  segment_edge_coverage uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i), .done_o(done_o), .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // delta * t / 2^16, rounded half away from zero
  function automatic longint scale_by_proj(longint delta, longint t);
    longint unsigned mag;
    longint unsigned prod;
    mag  = (delta < 0) ? -delta : delta;
    prod = (mag * t + 64'd32768) >> 16;
    return (delta < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic result_t edge_coverage(item_t it, logic [FeatherW-1:0] fw);
    longint dx, dy, rx, ry, len2, dotp, t, ox, oy;
    longint unsigned dist_v, excess, r, smooth, cov, feather;
    result_t res;
    feather = (fw == 0) ? 1 : fw;
    dx   = longint'(it.end_x) - longint'(it.start_x);
    dy   = longint'(it.end_y) - longint'(it.start_y);
    rx   = longint'(it.point_x) - longint'(it.start_x);
    ry   = longint'(it.point_y) - longint'(it.start_y);
    len2 = dx * dx + dy * dy;
    t    = 0;
    if (len2 != 0) begin
      dotp = rx * dx + ry * dy;
      if (dotp <= 0) t = 0;
      else if (dotp >= len2) t = 65536;
      else t = (dotp <<< 16) / len2;
    end
    ox     = rx - scale_by_proj(dx, t);
    oy     = ry - scale_by_proj(dy, t);
    dist_v = int_sqrt(ox * ox + oy * oy);
    r      = 0;
    if (dist_v > it.half_width) begin
      excess = dist_v - it.half_width;
      r = (excess >= feather) ? 65536 : (excess << 16) / feather;
    end
    smooth = (r * r * (3 * 65536 - 2 * r) + (64'd1 << 31)) >> 32;
    cov    = (smooth >= 65536) ? 0 : 65536 - smooth;
    if (cov > 65535) cov = 65535;
    res.coverage = cov[15:0];
    res.distance = (dist_v > 65535) ? 16'hFFFF : dist_v[15:0];
    return res;
  endfunction

  // accept items and compare results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc_cnt <= cyc_cnt + 1;
      if (start && !busy) begin
        coverage_q.push_back(row_typed ? row_want : edge_coverage(item_i, feather_shadow));
      end
      if (done_o) begin
        if (coverage_q.size() == 0) begin
          $error("result with nothing expected: cov %0d dist %0d",
                 result_o.coverage, result_o.distance);
          err_cnt++;
        end else begin
          result_t exp_r;
          exp_r = coverage_q.pop_front();
          if (result_o.coverage !== exp_r.coverage) begin
            $error("coverage: expected %0d actual %0d", exp_r.coverage, result_o.coverage);
            err_cnt++;
          end
          if (result_o.distance !== exp_r.distance) begin
            $error("distance: expected %0d actual %0d", exp_r.distance, result_o.distance);
            err_cnt++;
          end
        end
      end
      if (cyc_cnt > 400000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic item_t mk(int px, int py, int sx, int sy, int ex, int ey, int hw);
    item_t it;
    it.point_x = CoordW'(px); it.point_y = CoordW'(py);
    it.start_x = CoordW'(sx); it.start_y = CoordW'(sy);
    it.end_x = CoordW'(ex); it.end_y = CoordW'(ey);
    it.half_width = HalfW'(hw);
    return it;
  endfunction

  task automatic send_item(item_t it, bit typed, result_t want, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start     <= 1'b1;
    item_i    <= it;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (coverage_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_feather(logic [FeatherW-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    feather_shadow = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic item_t rand_item(logic [FeatherW-1:0] fw);
    item_t        it;
    logic [127:0] raw;
    int           span;
    raw  = {$urandom, $urandom, $urandom, $urandom};
    it   = raw[$bits(item_t)-1:0];
    span = 2 * fw + 1024;
    case ($urandom_range(3))
      0: ;  // fully random
      1: begin  // local segment, point near it
        it.end_x   = it.start_x + CoordW'($signed($urandom_range(0, 2 * span) - span));
        it.end_y   = it.start_y + CoordW'($signed($urandom_range(0, 2 * span) - span));
        it.point_x = it.start_x + CoordW'($signed($urandom_range(0, 4 * span) - span));
        it.point_y = it.start_y + CoordW'($signed($urandom_range(0, 4 * span) - span));
      end
      2: begin  // zero-length segment
        it.end_x   = it.start_x;
        it.end_y   = it.start_y;
        it.point_x = it.start_x + CoordW'($signed($urandom_range(0, 2 * span) - span));
        it.point_y = it.start_y + CoordW'($signed($urandom_range(0, 2 * span) - span));
      end
      default: begin  // point close to the edge band
        it.end_x   = it.start_x + CoordW'($signed($urandom_range(0, 8191) - 4096));
        it.end_y   = it.start_y + CoordW'($signed($urandom_range(0, 8191) - 4096));
        it.point_x = it.start_x + CoordW'($signed($urandom_range(0, 2 * span) - span / 2));
        it.point_y = it.start_y + CoordW'($signed($urandom_range(0, 2 * span) - span / 2));
        it.half_width = HalfW'($urandom_range(0, 2 * span));
      end
    endcase
    return it;
  endfunction

  initial begin
    stim_row_t       directed[$];
    result_t         none;
    int              idle_pct[3];
    logic [FeatherW-1:0] feathers[3];
    none = '0;
    idle_pct = '{22, 86, 0};
    feathers = '{12'd0, 12'd4095, 12'd1};
    rst_ni = 1'b0; start = 1'b0; item_i = '0; cfg_we_i = 1'b0; cfg_wdata_i = '0;
    row_typed = 1'b0; row_want = '0;
    feather_shadow = FeatherReset;
    err_cnt = 0; cyc_cnt = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // point on a zero-length segment: distance 0, full coverage
    directed.push_back('{mk(0, 0, 0, 0, 0, 0, 0), 1, '{16'hFFFF, 16'h0}});
    // opposite corners: distance saturates, coverage 0
    directed.push_back('{mk(-32768, -32768, 32767, 32767, 32767, 32767, 0),
                         1, '{16'h0, 16'hFFFF}});
    directed.push_back('{mk(32767, 32767, -32768, -32768, -32768, -32768, 4095),
                         1, '{16'h0, 16'hFFFF}});
    directed.push_back('{mk(0, 256, -512, 0, 512, 0, 0), 0, none});
    directed.push_back('{mk(0, 128, -512, 0, 512, 0, 0), 0, none});
    directed.push_back('{mk(1024, 64, -512, 0, 512, 0, 0), 0, none});
    directed.push_back('{mk(-1024, -64, -512, 0, 512, 0, 0), 0, none});
    directed.push_back('{mk(100, 300, 0, 0, 0, 0, 200), 0, none});
    directed.push_back('{mk(100, 300, 0, 0, 0, 0, 4095), 0, none});
    directed.push_back('{mk(77, 33, 10, 10, 300, 200, 20), 0, none});
    directed.push_back('{mk(-1, -1, 32767, -32768, -32768, 32767, 4095), 0, none});
    directed.push_back('{mk(32767, -32768, -32768, -32768, 32767, 32767, 100), 0, none});
    directed.push_back('{mk(5, 5, 5, 5, 6, 5, 0), 0, none});
    directed.push_back('{mk(300, 300, 0, 0, 1, 1, 1), 0, none});
    foreach (directed[i]) send_item(directed[i].it, directed[i].typed, directed[i].want, 0);

    for (int ph = 0; ph < 3; ph++) begin
      write_feather(ph == 2 ? 12'($urandom_range(1, 4094)) : feathers[ph]);
      for (int n = 0; n < 670; n++) begin
        if (ph == 0 && n == 300) begin
          drain();
          write_feather(feathers[2]);
        end
        send_item(rand_item(feather_shadow), 0, none, idle_pct[ph]);
      end
    end

    drain();
    repeat (70) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sec_pkg.sv
rtl/sec_div.sv
rtl/sec_sqrt.sv
rtl/segment_edge_coverage.sv
dv/tb.sv
